// ===== rtl/nnrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nnrs_pkg;

    // Sizing
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_COPIES  = 10;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int WCMP_W      = (ADDR_W + 1 > 13) ? ADDR_W + 1 : 13;
    localparam int CNT_W       = $clog2(MAX_COPIES + 1);
    localparam int POS_W       = 20;
    localparam int DIV_NUM_W   = POS_W + 1;
    localparam int DIV_DEN_W   = 4;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
    localparam int PIX_W       = 24;
    localparam int DIM_W       = 13;
    localparam int UP_W        = 7;
    localparam int OWED_W      = 4;
    localparam int OWED_MAX    = (1 << OWED_W) - 1;
    localparam int OUT_DATA_W  = 32;

    // Config port
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_UP     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DOWN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SRC_W  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCL_W  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCL_H  = 3'd4;

    typedef struct packed {
        logic [UP_W-1:0]      up_factor;
        logic [DIV_DEN_W-1:0] down_factor;
        logic [DIM_W-1:0]     source_width;
        logic [DIM_W-1:0]     scaled_width;
        logic [DIM_W-1:0]     scaled_height;
    } cfg_t;

    // Result payload, MSB first
    typedef struct packed {
        logic [OWED_W-1:0] rows_owed;
        logic [1:0]        pad_bytes;
        logic              row_end;
        logic [7:0]        blue_out;
        logic [7:0]        green_out;
        logic [7:0]        red_out;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ROW1,
        ST_ROW2,
        ST_DIV,
        ST_ROW3,
        ST_ROW4,
        ST_EMIT,
        ST_FINAL
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/nnrs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nnrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nnrs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module nnrs_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [nnrs_pkg::DIV_NUM_W-1:0]  num,
    input  wire logic [nnrs_pkg::DIV_DEN_W-1:0]  den,
    output logic                                 done,
    output logic      [nnrs_pkg::DIV_NUM_W-1:0]  quot
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [nnrs_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [nnrs_pkg::DIV_NUM_W-1:0]    quo_reg, quo_next;
    logic [nnrs_pkg::DIV_DEN_W-1:0]    rem_reg, rem_next;
    logic [nnrs_pkg::DIV_DEN_W-1:0]    den_reg, den_next;
    logic [nnrs_pkg::DIV_DEN_W:0]      trial;
    logic [nnrs_pkg::DIV_DEN_W:0]      diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[nnrs_pkg::DIV_NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[nnrs_pkg::DIV_DEN_W-1:0];
                quo_next = {quo_reg[nnrs_pkg::DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[nnrs_pkg::DIV_DEN_W-1:0];
                quo_next = {quo_reg[nnrs_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == nnrs_pkg::DIV_CNT_W'(nnrs_pkg::DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/nnrs_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// APB register file.
module nnrs_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [nnrs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [nnrs_pkg::PDATA_W-1:0]  pwdata,
    output logic      [nnrs_pkg::PDATA_W-1:0]  prdata,
    output nnrs_pkg::cfg_t                     cfg
);

    nnrs_pkg::cfg_t                   cfg_reg, cfg_next;
    logic [nnrs_pkg::REG_IDX_W-1:0]   idx;
    logic                             wr;

    assign idx = paddr[nnrs_pkg::PADDR_W-1:2];
    assign wr  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (idx)
                nnrs_pkg::REG_UP: begin
                    cfg_next.up_factor = pwdata[nnrs_pkg::UP_W-1:0];
                end
                nnrs_pkg::REG_DOWN: begin
                    cfg_next.down_factor = pwdata[nnrs_pkg::DIV_DEN_W-1:0];
                end
                nnrs_pkg::REG_SRC_W: begin
                    cfg_next.source_width = pwdata[nnrs_pkg::DIM_W-1:0];
                end
                nnrs_pkg::REG_SCL_W: begin
                    cfg_next.scaled_width = pwdata[nnrs_pkg::DIM_W-1:0];
                end
                nnrs_pkg::REG_SCL_H: begin
                    cfg_next.scaled_height = pwdata[nnrs_pkg::DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            nnrs_pkg::REG_UP:    prdata = nnrs_pkg::PDATA_W'(cfg_reg.up_factor);
            nnrs_pkg::REG_DOWN:  prdata = nnrs_pkg::PDATA_W'(cfg_reg.down_factor);
            nnrs_pkg::REG_SRC_W: prdata = nnrs_pkg::PDATA_W'(cfg_reg.source_width);
            nnrs_pkg::REG_SCL_W: prdata = nnrs_pkg::PDATA_W'(cfg_reg.scaled_width);
            nnrs_pkg::REG_SCL_H: prdata = nnrs_pkg::PDATA_W'(cfg_reg.scaled_height);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.up_factor     <= nnrs_pkg::UP_W'(1);
            cfg_reg.down_factor   <= nnrs_pkg::DIV_DEN_W'(1);
            cfg_reg.source_width  <= nnrs_pkg::DIM_W'(1);
            cfg_reg.scaled_width  <= nnrs_pkg::DIM_W'(1);
            cfg_reg.scaled_height <= nnrs_pkg::DIM_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/nearest_neighbor_rational_scaler_top.sv =====
// Push inside a row: the accepting edge leads to the emit state, which gives one result per copy.
// Push ending a source row: the row states and the row-count divider run before any results.
// Replay: the line store read adds the read state before emission. A new input is taken only
// once all results of the previous one have been issued; up to 10 copies, paced by m_tready.
// Reset (aresetn low, synchronous): walk counters and handshakes clear, registers return to 1;
// the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_rational_scaler_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [23:0]                      s_tdata,   // red_in, green_in, blue_in
    input  wire logic                             s_tuser,   // mode (0 push, 1 replay)
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], row_end[24], pad_bytes[26:25],
    // rows_owed[30:27], zero[31]
    output logic [nnrs_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tlast,   // last result of the input item
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [nnrs_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [nnrs_pkg::PDATA_W-1:0]     pwdata,
    output logic      [nnrs_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready
);

    localparam int AW = nnrs_pkg::ADDR_W;
    localparam int PW = nnrs_pkg::POS_W;
    localparam int DW = nnrs_pkg::DIM_W;
    localparam int WW = nnrs_pkg::WCMP_W;

    nnrs_pkg::cfg_t cfg;

    nnrs_pkg::state_t state_reg, state_next;

    // column walk
    logic [AW-1:0]                  sc_reg, sc_next;
    logic [PW-1:0]                  cb_reg, cb_next;
    logic [PW-1:0]                  ncp_reg, ncp_next;
    logic [DW-1:0]                  oc_reg, oc_next;
    // row walk
    logic [PW-1:0]                  rb_reg, rb_next;
    logic [PW-1:0]                  nrp_reg, nrp_next;
    logic [DW-1:0]                  or_reg, or_next;
    logic [nnrs_pkg::OWED_W-1:0]    rrl_reg, rrl_next;
    // per item
    logic [nnrs_pkg::PIX_W-1:0]     pix_reg, pix_next;
    logic                           owns_reg, owns_next;
    logic                           fin_reg, fin_next;
    logic [nnrs_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]                  n_reg, n_next;
    // output register
    logic                           ov_reg, ov_next;
    nnrs_pkg::out_t                 od_reg, od_next;
    logic                           ol_reg, ol_next;

    // effective config
    logic [nnrs_pkg::UP_W-1:0]      up_eff;
    logic [nnrs_pkg::DIV_DEN_W-1:0] down_eff;
    logic [WW-1:0]                  width_eff;
    logic [PW-1:0]                  up_pos;
    logic [PW-1:0]                  down_pos;
    logic [PW-1:0]                  col_limit;
    logic [PW-1:0]                  row_limit;

    logic                           accept;
    logic                           is_push;
    logic                           slot_free;
    logic                           row_lt;
    logic                           cond;
    logic                           cond_nxt;
    logic                           fire;
    logic [DW-1:0]                  oc_inc;
    logic [PW-1:0]                  ncp_inc;
    logic [nnrs_pkg::CNT_W-1:0]     cnt_inc;
    logic [AW-1:0]                  sc_eff;
    logic                           fin_acc;
    logic [DW-1:0]                  rows_room;
    logic [DW+nnrs_pkg::DIV_DEN_W-1:0] n_prod;

    // line store ports
    logic                           ram_we;
    logic                           ram_re;
    logic [nnrs_pkg::PIX_W-1:0]     ram_rdata;

    // divider
    logic                             div_start;
    logic [nnrs_pkg::DIV_NUM_W-1:0]   div_num;
    logic                             div_done;
    logic [nnrs_pkg::DIV_NUM_W-1:0]   div_quot;

    assign pready = 1'b1;

    nnrs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Line store: pushes write at the accepting edge, replays read there.
    nnrs_ram #(
        .WIDTH (nnrs_pkg::PIX_W),
        .DEPTH (nnrs_pkg::MAX_WIDTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (sc_eff),
        .wr_data (s_tdata[nnrs_pkg::PIX_W-1:0]),
        .rd_en   (ram_re),
        .rd_addr (sc_reg),
        .rd_data (ram_rdata)
    );

    // Ceiling division for the number of output rows a source row owns.
    nnrs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (down_eff),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Zero factors act as one; source width is clamped to the line store.
    always_comb begin
        up_eff   = (cfg.up_factor == '0) ? nnrs_pkg::UP_W'(1) : cfg.up_factor;
        down_eff = (cfg.down_factor == '0) ? nnrs_pkg::DIV_DEN_W'(1) : cfg.down_factor;
        if (cfg.source_width == '0) begin
            width_eff = WW'(1);
        end else if (WW'(cfg.source_width) > WW'(nnrs_pkg::MAX_WIDTH)) begin
            width_eff = WW'(nnrs_pkg::MAX_WIDTH);
        end else begin
            width_eff = WW'(cfg.source_width);
        end
    end

    assign up_pos    = PW'(up_eff);
    assign down_pos  = PW'(down_eff);
    assign col_limit = cb_reg + up_pos;
    assign row_limit = rb_reg + up_pos;
    assign row_lt    = nrp_reg < row_limit;

    assign accept    = s_tvalid && s_tready;
    assign is_push   = !s_tuser;
    assign slot_free = !ov_reg || m_tready;

    // A push while replay rows are owed restarts the column walk.
    assign sc_eff  = (rrl_reg != '0) ? '0 : sc_reg;
    assign fin_acc = is_push ? (WW'(sc_eff) + WW'(1) >= width_eff)
                             : (WW'(sc_reg) + WW'(1) >= width_eff);

    // copy emission: current copy and look-ahead for the next one
    assign oc_inc   = oc_reg + 1'b1;
    assign ncp_inc  = ncp_reg + down_pos;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cond     = (cnt_reg < nnrs_pkg::CNT_W'(nnrs_pkg::MAX_COPIES))
                      && (oc_reg < cfg.scaled_width) && (ncp_reg < col_limit);
    assign cond_nxt = (cnt_inc < nnrs_pkg::CNT_W'(nnrs_pkg::MAX_COPIES))
                      && (oc_inc < cfg.scaled_width) && (ncp_inc < col_limit);
    assign fire     = (state_reg == nnrs_pkg::ST_EMIT) && cond && slot_free;

    assign rows_room = cfg.scaled_height - or_reg;
    assign n_prod    = n_reg * down_eff;

    assign div_num = row_lt ? ({1'b0, row_limit - nrp_reg} + nnrs_pkg::DIV_NUM_W'(down_eff)
                               - nnrs_pkg::DIV_NUM_W'(1))
                            : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nnrs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (is_push) begin
                        if (fin_acc) begin
                            state_next = nnrs_pkg::ST_ROW1;
                        end else if (row_lt && (or_reg < cfg.scaled_height)) begin
                            state_next = nnrs_pkg::ST_EMIT;
                        end else begin
                            state_next = nnrs_pkg::ST_FINAL;
                        end
                    end else if (rrl_reg != '0) begin
                        state_next = nnrs_pkg::ST_READ;
                    end
                end
            end
            nnrs_pkg::ST_READ: state_next = nnrs_pkg::ST_EMIT;
            nnrs_pkg::ST_ROW1: state_next = nnrs_pkg::ST_ROW2;
            nnrs_pkg::ST_ROW2: state_next = nnrs_pkg::ST_DIV;
            nnrs_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = nnrs_pkg::ST_ROW3;
                end
            end
            nnrs_pkg::ST_ROW3: state_next = nnrs_pkg::ST_ROW4;
            nnrs_pkg::ST_ROW4: begin
                state_next = owns_reg ? nnrs_pkg::ST_EMIT : nnrs_pkg::ST_FINAL;
            end
            nnrs_pkg::ST_EMIT: begin
                if (!cond || (slot_free && !cond_nxt)) begin
                    state_next = nnrs_pkg::ST_FINAL;
                end
            end
            nnrs_pkg::ST_FINAL: state_next = nnrs_pkg::ST_IDLE;
            default:            state_next = nnrs_pkg::ST_IDLE;
        endcase
    end

    // handshake and memory strobes
    always_comb begin
        s_tready  = (state_reg == nnrs_pkg::ST_IDLE);
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            nnrs_pkg::ST_IDLE: begin
                ram_we = accept && is_push;
                ram_re = accept && !is_push && (rrl_reg != '0);
            end
            nnrs_pkg::ST_ROW2: div_start = 1'b1;
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        sc_next   = sc_reg;
        cb_next   = cb_reg;
        ncp_next  = ncp_reg;
        oc_next   = oc_reg;
        rb_next   = rb_reg;
        nrp_next  = nrp_reg;
        or_next   = or_reg;
        rrl_next  = rrl_reg;
        pix_next  = pix_reg;
        owns_next = owns_reg;
        fin_next  = fin_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        case (state_reg)
            nnrs_pkg::ST_IDLE: begin
                if (accept) begin
                    cnt_next = '0;
                    fin_next = fin_acc;
                    if (is_push) begin
                        pix_next  = s_tdata[nnrs_pkg::PIX_W-1:0];
                        owns_next = row_lt && (or_reg < cfg.scaled_height);
                        rrl_next  = '0;
                        if (rrl_reg != '0) begin
                            sc_next  = '0;
                            cb_next  = '0;
                            ncp_next = '0;
                            oc_next  = '0;
                        end
                    end else if (rrl_reg != '0) begin
                        owns_next = 1'b1;
                        if (fin_acc) begin
                            rrl_next = rrl_reg - 1'b1;
                        end
                    end
                end
            end
            nnrs_pkg::ST_READ: pix_next = ram_rdata;
            nnrs_pkg::ST_ROW1: begin
                if (owns_reg) begin
                    or_next  = or_reg + 1'b1;
                    nrp_next = nrp_reg + down_pos;
                end
            end
            nnrs_pkg::ST_ROW3: begin
                if (!row_lt || (or_reg >= cfg.scaled_height)) begin
                    n_next = '0;
                end else if (div_quot > nnrs_pkg::DIV_NUM_W'(rows_room)) begin
                    n_next = rows_room;
                end else begin
                    n_next = div_quot[DW-1:0];
                end
            end
            nnrs_pkg::ST_ROW4: begin
                or_next  = or_reg + n_reg;
                nrp_next = nrp_reg + PW'(n_prod);
                rrl_next = (n_reg > DW'(nnrs_pkg::OWED_MAX)) ?
                           nnrs_pkg::OWED_W'(nnrs_pkg::OWED_MAX) : n_reg[nnrs_pkg::OWED_W-1:0];
                rb_next  = row_limit;
            end
            nnrs_pkg::ST_EMIT: begin
                if (fire) begin
                    oc_next  = oc_inc;
                    ncp_next = ncp_inc;
                    cnt_next = cnt_inc;
                end
            end
            nnrs_pkg::ST_FINAL: begin
                if (fin_reg) begin
                    sc_next  = '0;
                    cb_next  = '0;
                    ncp_next = '0;
                    oc_next  = '0;
                end else begin
                    sc_next = sc_reg + 1'b1;
                    cb_next = col_limit;
                end
            end
            default: begin
            end
        endcase
    end

    // output register: a waiting result does not block the next input transfer
    always_comb begin
        ov_next = ov_reg;
        od_next = od_reg;
        ol_next = ol_reg;
        if (fire) begin
            ov_next           = 1'b1;
            od_next.red_out   = pix_reg[7:0];
            od_next.green_out = pix_reg[15:8];
            od_next.blue_out  = pix_reg[23:16];
            od_next.row_end   = (oc_inc == cfg.scaled_width);
            od_next.pad_bytes = (oc_inc == cfg.scaled_width) ? cfg.scaled_width[1:0] : 2'd0;
            od_next.rows_owed = rrl_reg;
            ol_next           = !cond_nxt;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nnrs_pkg::ST_IDLE;
            sc_reg    <= '0;
            cb_reg    <= '0;
            ncp_reg   <= '0;
            oc_reg    <= '0;
            rb_reg    <= '0;
            nrp_reg   <= '0;
            or_reg    <= '0;
            rrl_reg   <= '0;
            owns_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            cb_reg    <= cb_next;
            ncp_reg   <= ncp_next;
            oc_reg    <= oc_next;
            rb_reg    <= rb_next;
            nrp_reg   <= nrp_next;
            or_reg    <= or_next;
            rrl_reg   <= rrl_next;
            owns_reg  <= owns_next;
            fin_reg   <= fin_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
        pix_reg <= pix_next;
        n_reg   <= n_next;
        od_reg  <= od_next;
        ol_reg  <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = nnrs_pkg::OUT_DATA_W'(od_reg);
    assign m_tlast  = ol_reg;

endmodule

`default_nettype wire

// ===== rtl/nnrs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nnrs_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [nnrs_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [nnrs_pkg::PADDR_W-1:0]  paddr,
    input wire logic [nnrs_pkg::PDATA_W-1:0]  pwdata,
    input wire logic [nnrs_pkg::PDATA_W-1:0]  prdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // no new input while an item still has results to deliver
    a_no_accept_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken before all results of an item");

    // a write to the up factor is visible on the next read
    a_up_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(psel && penable && pwrite
                                && paddr[nnrs_pkg::PADDR_W-1:2] == nnrs_pkg::REG_UP)
        && psel && !pwrite && paddr[nnrs_pkg::PADDR_W-1:2] == nnrs_pkg::REG_UP
        |-> prdata == nnrs_pkg::PDATA_W'($past(pwdata[nnrs_pkg::UP_W-1:0])))
        else $error("up factor readback mismatch");

endmodule

bind nearest_neighbor_rational_scaler_top nnrs_checker u_nnrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

`default_nettype wire
